// ===== hdl/vog_pkg.sv =====
// ----------------------------------------------------------------------------
// vog_pkg: shared types and constants of the voxel occupancy grid
// Grid geometry, command codes, config register indexes, memory word layouts.
// ----------------------------------------------------------------------------
package vog_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int GRID_X      = 16;
  localparam int GRID_Y      = 16;
  localparam int GRID_Z      = 16;
  localparam int CELLS       = GRID_X * GRID_Y * GRID_Z;

  localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);

  // Q16.8 coordinate
  typedef logic signed [23:0] q_t;
  localparam logic signed [24:0] Q_MAX = 25'sd8388607;
  localparam logic signed [24:0] Q_MIN = -25'sd8388608;

  // command codes
  localparam logic [3:0] CMD_START    = 4'd0;
  localparam logic [3:0] CMD_GROUND   = 4'd1;
  localparam logic [3:0] CMD_ACTIVE   = 4'd2;
  localparam logic [3:0] CMD_EFFECT   = 4'd3;
  localparam logic [3:0] CMD_FOCUS    = 4'd4;
  localparam logic [3:0] CMD_LOOKUP   = 4'd5;
  localparam logic [3:0] CMD_BLOCKED  = 4'd6;
  localparam logic [3:0] CMD_CONTAINS = 4'd7;
  localparam logic [3:0] CMD_READ     = 4'd8;
  localparam logic [3:0] CMD_COUNT    = 4'd9;

  // config register indexes
  localparam logic [3:0] REG_HALF_H = 4'd0;
  localparam logic [3:0] REG_HALF_V = 4'd1;

  // entry word
  typedef struct packed {
    logic [1:0]  kind;
    q_t          x;
    q_t          y;
    q_t          z;
    logic [63:0] data;
  } entry_t;

  // cell word
  typedef struct packed {
    logic                valid;
    logic [ENTRY_AW-1:0] idx;
    logic [31:0]         stamp;
  } cell_t;

  // coordinate unit results
  typedef struct packed {
    q_t                 loc_x;
    q_t                 loc_y;
    q_t                 loc_z;
    q_t                 base_x;
    q_t                 base_y;
    q_t                 base_z;
    logic               in_box;
    logic               cell_ok;
    logic [CELL_AW-1:0] cell_addr;
  } geom_t;

  // result word
  typedef struct packed {
    logic               hit;
    logic               table_full;
    logic               outside_grid;
    logic [7:0]         entry_index;
    logic [1:0]         entry_kind;
    q_t                 entry_x;
    q_t                 entry_y;
    q_t                 entry_z;
    logic [63:0]        entry_data;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

// ===== hdl/vog_ram.sv =====
// ----------------------------------------------------------------------------
// vog_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vog_geom.sv =====
// ----------------------------------------------------------------------------
// vog_geom: coordinate unit
// Base corner, world-to-local conversion, cell addressing, box test.
// ----------------------------------------------------------------------------
module vog_geom (
  input  vog_pkg::q_t    pos_x,
  input  vog_pkg::q_t    pos_y,
  input  vog_pkg::q_t    pos_z,
  input  vog_pkg::q_t    base_x,
  input  vog_pkg::q_t    base_y,
  input  vog_pkg::q_t    base_z,
  input  logic [15:0]    half_h,
  input  logic [15:0]    half_v,
  input  logic           use_raw,
  output vog_pkg::geom_t geom
);
  import vog_pkg::*;

  localparam logic signed [24:0] LIM_LO = -25'sd255;
  localparam logic signed [24:0] LIM_X  = 25'(GRID_X * 256);
  localparam logic signed [24:0] LIM_Y  = 25'(GRID_Y * 256);
  localparam logic signed [24:0] LIM_Z  = 25'(GRID_Z * 256);
  localparam logic signed [24:0] SPAN_X = 25'((GRID_X - 1) * 256);
  localparam logic signed [24:0] SPAN_Y = 25'((GRID_Y - 1) * 256);
  localparam logic signed [24:0] SPAN_Z = 25'((GRID_Z - 1) * 256);

  function automatic q_t sat24(input logic signed [24:0] v);
    if (v > Q_MAX) begin
      return Q_MAX[23:0];
    end else if (v < Q_MIN) begin
      return Q_MIN[23:0];
    end
    return v[23:0];
  endfunction

  // floor(p - h) to a whole cell, clamped at the bottom of the range
  function automatic q_t floor_base(input q_t p, input logic [15:0] h);
    logic signed [25:0] d;
    logic signed [25:0] f;
    d = {{2{p[23]}}, p} - $signed({10'd0, h});
    f = {d[25:8], 8'd0};
    if (f < 26'(Q_MIN)) begin
      return Q_MIN[23:0];
    end
    return f[23:0];
  endfunction

  function automatic logic signed [24:0] ext(input q_t v);
    return {v[23], v};
  endfunction

  q_t                 cx_src, cy_src, cz_src;
  logic               ok_x, ok_y, ok_z;
  logic [15:0]        ix, iy, iz;

  always_comb begin
    geom.base_x = floor_base(pos_x, half_h);
    geom.base_y = floor_base(pos_y, half_h);
    geom.base_z = floor_base(pos_z, half_v);

    geom.loc_x = sat24(ext(pos_x) - ext(base_x));
    geom.loc_y = sat24(ext(pos_y) - ext(base_y));
    geom.loc_z = sat24(ext(pos_z) - ext(base_z));

    geom.in_box = (ext(pos_x) >= ext(base_x)) && (ext(pos_x) <= ext(base_x) + SPAN_X) &&
                  (ext(pos_y) >= ext(base_y)) && (ext(pos_y) <= ext(base_y) + SPAN_Y) &&
                  (ext(pos_z) >= ext(base_z)) && (ext(pos_z) <= ext(base_z) + SPAN_Z);

    // lookups take local coordinates straight from the command
    cx_src = use_raw ? pos_x : geom.loc_x;
    cy_src = use_raw ? pos_y : geom.loc_y;
    cz_src = use_raw ? pos_z : geom.loc_z;

    // truncation toward zero: anything above -256 lands in cell 0
    ok_x = (ext(cx_src) >= LIM_LO) && (ext(cx_src) < LIM_X);
    ok_y = (ext(cy_src) >= LIM_LO) && (ext(cy_src) < LIM_Y);
    ok_z = (ext(cz_src) >= LIM_LO) && (ext(cz_src) < LIM_Z);
    ix = cx_src[23] ? 16'd0 : cx_src[23:8];
    iy = cy_src[23] ? 16'd0 : cy_src[23:8];
    iz = cz_src[23] ? 16'd0 : cz_src[23:8];

    geom.cell_ok   = ok_x && ok_y && ok_z;
    geom.cell_addr = CELL_AW'((32'(iz) * GRID_Y + 32'(iy)) * GRID_X + 32'(ix));
  end

endmodule

// ===== hdl/epoch_tagged_voxel_occupancy_grid.sv =====
// ----------------------------------------------------------------------------
// epoch_tagged_voxel_occupancy_grid: local 3D occupancy grid with epoch tags
// Entry table and cell store in block RAM, lazy expiry by epoch stamp.
// ----------------------------------------------------------------------------
// Path per command: start, register, contains, count, a read past the count and
// an off-grid lookup end in ST_EXEC; a read entry goes on to ST_ENTRY; a lookup
// or blocked test goes to ST_CELL and, if the cell is live, on to ST_ENTRY (cell
// RAM read, then entry RAM read); done is registered. One command at a time: busy
// is high until done, and the next word may be accepted in the done cycle. Reset:
// a clearing pass writes every cell invalid, busy high.
module epoch_tagged_voxel_occupancy_grid (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [63:0]        payload,
  input  logic [1:0]         query_kind,
  // result channel
  output logic               done,
  output logic               hit,
  output logic               table_full,
  output logic               outside_grid,
  output logic [7:0]         entry_index,
  output logic [1:0]         entry_kind,
  output logic signed [23:0] entry_x,
  output logic signed [23:0] entry_y,
  output logic signed [23:0] entry_z,
  output logic [63:0]        entry_data,
  output logic [8:0]         entry_count,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import vog_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset sweep of cell RAM
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;  // decode, address compute, writes
  localparam logic [2:0] ST_CELL  = 3'd3;  // cell word back from RAM
  localparam logic [2:0] ST_ENTRY = 3'd4;  // entry word back from RAM

  logic [2:0] state, state_next;

  // configuration
  logic [15:0] half_h, half_v;

  // grid state
  logic [31:0]        epoch, epoch_next;
  q_t                 base_x, base_y, base_z;
  q_t                 base_x_next, base_y_next, base_z_next;
  logic [COUNT_W-1:0] count_used, count_next;
  logic [CELL_AW-1:0] clr, clr_next;

  // latched command word
  logic [3:0]  cmd_r;
  q_t          px_r, py_r, pz_r;
  logic [63:0] payload_r;
  logic [1:0]  qkind_r;

  // index of the entry being read back
  logic [ENTRY_AW-1:0] ridx, ridx_next;

  // result register
  result_t res, res_next;
  logic    done_next;

  // memory ports
  logic                ent_we;
  logic [ENTRY_AW-1:0] ent_waddr, ent_raddr;
  entry_t              ent_wdata, ent_rdata;
  logic                cell_we;
  logic [CELL_AW-1:0]  cell_waddr;
  cell_t               cell_wdata, cell_rdata;

  geom_t geom;
  logic  table_is_full;
  logic  marks_cell;

  vog_geom u_geom (
    .pos_x  (px_r),
    .pos_y  (py_r),
    .pos_z  (pz_r),
    .base_x (base_x),
    .base_y (base_y),
    .base_z (base_z),
    .half_h (half_h),
    .half_v (half_v),
    .use_raw(cmd_r == CMD_LOOKUP || cmd_r == CMD_BLOCKED),
    .geom   (geom)
  );

  // entry table: kind, local position and payload per slot
  vog_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  // cell store: valid, owning entry, epoch stamp
  vog_ram #(
    .WIDTH($bits(cell_t)),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(geom.cell_addr),
    .rdata(cell_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign table_is_full = (count_used >= COUNT_W'(MAX_ENTRIES));
  assign marks_cell    = (cmd_r == CMD_GROUND) || (cmd_r == CMD_ACTIVE);

  always_comb begin
    state_next  = state;
    epoch_next  = epoch;
    base_x_next = base_x;
    base_y_next = base_y;
    base_z_next = base_z;
    count_next  = count_used;
    clr_next    = clr;
    ridx_next   = ridx;
    res_next    = '0;
    done_next   = 1'b0;

    ent_we          = 1'b0;
    ent_waddr       = count_used[ENTRY_AW-1:0];
    ent_wdata.kind  = 2'(cmd_r - CMD_GROUND);
    ent_wdata.x     = (cmd_r == CMD_EFFECT) ? px_r : geom.loc_x;
    ent_wdata.y     = (cmd_r == CMD_EFFECT) ? py_r : geom.loc_y;
    ent_wdata.z     = (cmd_r == CMD_EFFECT) ? pz_r : geom.loc_z;
    ent_wdata.data  = payload_r;
    if (cmd_r == CMD_GROUND) begin
      ent_wdata.data = {48'd0, payload_r[15:0]};
    end else if (cmd_r == CMD_FOCUS) begin
      ent_wdata.data = '0;
    end
    ent_raddr = (state == ST_CELL) ? cell_rdata.idx : payload_r[ENTRY_AW-1:0];

    cell_we          = 1'b0;
    cell_waddr       = geom.cell_addr;
    cell_wdata.valid = 1'b1;
    cell_wdata.idx   = count_used[ENTRY_AW-1:0];
    cell_wdata.stamp = epoch;

    unique case (state)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr;
        cell_wdata = '0;
        clr_next   = clr + 1'b1;
        if (clr == CELL_AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        case (cmd_r) inside
          CMD_START: begin
            epoch_next  = payload_r[31:0];
            base_x_next = geom.base_x;
            base_y_next = geom.base_y;
            base_z_next = geom.base_z;
            count_next  = '0;
          end
          CMD_GROUND, CMD_ACTIVE, CMD_EFFECT, CMD_FOCUS: begin
            if (table_is_full) begin
              res_next.table_full = 1'b1;
            end else begin
              ent_we                = 1'b1;
              cell_we               = marks_cell && geom.cell_ok;
              count_next            = count_used + 1'b1;
              res_next.hit          = 1'b1;
              res_next.outside_grid = marks_cell && !geom.cell_ok;
              res_next.entry_index  = 8'(count_used[ENTRY_AW-1:0]);
              res_next.entry_kind   = ent_wdata.kind;
              res_next.entry_x      = ent_wdata.x;
              res_next.entry_y      = ent_wdata.y;
              res_next.entry_z      = ent_wdata.z;
              res_next.entry_data   = ent_wdata.data;
            end
          end
          CMD_LOOKUP, CMD_BLOCKED: begin
            if (!geom.cell_ok) begin
              res_next.outside_grid = 1'b1;
            end else begin
              state_next = ST_CELL;
              done_next  = 1'b0;
            end
          end
          CMD_CONTAINS: begin
            res_next.hit          = geom.in_box;
            res_next.outside_grid = !geom.in_box;
          end
          CMD_READ: begin
            if (payload_r < 64'(count_used)) begin
              ridx_next  = payload_r[ENTRY_AW-1:0];
              state_next = ST_ENTRY;
              done_next  = 1'b0;
            end
          end
          default: begin
            // count and unused codes: count only
          end
        endcase
      end
      ST_CELL: begin
        // live only if set in this epoch
        if (cell_rdata.valid && cell_rdata.stamp == epoch) begin
          ridx_next  = cell_rdata.idx;
          state_next = ST_ENTRY;
        end else begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      ST_ENTRY: begin
        state_next           = ST_IDLE;
        done_next            = 1'b1;
        res_next.hit         = (cmd_r == CMD_BLOCKED) ? (ent_rdata.kind == qkind_r) : 1'b1;
        res_next.entry_index = 8'(ridx);
        res_next.entry_kind  = ent_rdata.kind;
        res_next.entry_x     = ent_rdata.x;
        res_next.entry_y     = ent_rdata.y;
        res_next.entry_z     = ent_rdata.z;
        res_next.entry_data  = ent_rdata.data;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_next.entry_count = count_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      epoch      <= '0;
      base_x     <= '0;
      base_y     <= '0;
      base_z     <= '0;
      count_used <= '0;
      done       <= 1'b0;
      half_h     <= 16'd2048;
      half_v     <= 16'd2048;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      epoch      <= epoch_next;
      base_x     <= base_x_next;
      base_y     <= base_y_next;
      base_z     <= base_z_next;
      count_used <= count_next;
      done       <= done_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HALF_H: half_h <= cfg_data;
          REG_HALF_V: half_v <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // command word and result word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r     <= command;
      px_r      <= pos_x;
      py_r      <= pos_y;
      pz_r      <= pos_z;
      payload_r <= payload;
      qkind_r   <= query_kind;
    end
    ridx <= ridx_next;
    res  <= res_next;
  end

  assign hit          = res.hit;
  assign table_full   = res.table_full;
  assign outside_grid = res.outside_grid;
  assign entry_index  = res.entry_index;
  assign entry_kind   = res.entry_kind;
  assign entry_x      = res.entry_x;
  assign entry_y      = res.entry_y;
  assign entry_z      = res.entry_z;
  assign entry_data   = res.entry_data;
  assign entry_count  = 9'(res.entry_count);

  // a word taken in starts work on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // no result leaves during the clearing sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !done)
    else $error("result during cell clear");

  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_used <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // a dropped registration never also reports success
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (!hit && entry_count == 9'(MAX_ENTRIES)))
    else $error("table full with hit or short count");

endmodule

// ===== verif/grid_checker.sv =====
// ----------------------------------------------------------------------------
// grid_checker: result checker for the voxel occupancy grid
// Mirrors the grid state from accepted command words and config writes,
// works out the reply to each command, and compares each done word to it.
// ----------------------------------------------------------------------------
module grid_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         busy,
  input  logic [3:0]   command,
  input  vog_pkg::q_t  pos_x,
  input  vog_pkg::q_t  pos_y,
  input  vog_pkg::q_t  pos_z,
  input  logic [63:0]  payload,
  input  logic [1:0]   query_kind,
  input  logic         done,
  input  logic         hit,
  input  logic         table_full,
  input  logic         outside_grid,
  input  logic [7:0]   entry_index,
  input  logic [1:0]   entry_kind,
  input  vog_pkg::q_t  entry_x,
  input  vog_pkg::q_t  entry_y,
  input  vog_pkg::q_t  entry_z,
  input  logic [63:0]  entry_data,
  input  logic [8:0]   entry_count,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fault_count,
  output int           awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import vog_pkg::*;

  localparam int CELL_Q = 256;

  // mirrored grid state
  logic [15:0] half_h, half_v;
  logic [31:0] epoch;
  longint      org_x, org_y, org_z;
  int unsigned used;
  logic [1:0]  e_kind [MAX_ENTRIES];
  longint      e_x    [MAX_ENTRIES];
  longint      e_y    [MAX_ENTRIES];
  longint      e_z    [MAX_ENTRIES];
  logic [63:0] e_data [MAX_ENTRIES];
  bit          c_valid [CELLS];
  int unsigned c_slot  [CELLS];
  logic [31:0] c_stamp [CELLS];

  result_t pending_replies [$];
  int      faults = 0;

  function automatic longint clamp24(input longint v);
    if (v < Q_MIN) return Q_MIN;
    if (v > Q_MAX) return Q_MAX;
    return v;
  endfunction

  // round down to a whole cell
  function automatic longint cell_floor(input longint v);
    return clamp24((v >>> 8) <<< 8);
  endfunction

  // cell address, -1 when outside; signed division truncates toward zero
  function automatic int cell_of(input longint lx, input longint ly, input longint lz);
    longint ix, iy, iz;
    ix = lx / CELL_Q;
    iy = ly / CELL_Q;
    iz = lz / CELL_Q;
    if (ix < 0 || ix >= GRID_X || iy < 0 || iy >= GRID_Y || iz < 0 || iz >= GRID_Z)
      return -1;
    return int'((iz * GRID_Y + iy) * GRID_X + ix);
  endfunction

  function automatic void put_entry(inout result_t r, input int unsigned slot);
    r.entry_index = slot[7:0];
    r.entry_kind  = e_kind[slot];
    r.entry_x     = q_t'(e_x[slot]);
    r.entry_y     = q_t'(e_y[slot]);
    r.entry_z     = q_t'(e_z[slot]);
    r.entry_data  = e_data[slot];
  endfunction

  // advance the mirror by one command and return its reply
  function automatic result_t grid_reply(input logic [3:0] cmd, input q_t px, input q_t py,
                                         input q_t pz, input logic [63:0] pl,
                                         input logic [1:0] qk);
    result_t     r;
    longint      x, y, z, lx, ly, lz;
    int          vox;
    int unsigned slot;
    r = '0;
    x = px;
    y = py;
    z = pz;
    case (cmd) inside
      CMD_START: begin
        epoch = pl[31:0];
        org_x = cell_floor(x - longint'(half_h));
        org_y = cell_floor(y - longint'(half_h));
        org_z = cell_floor(z - longint'(half_v));
        used  = 0;
      end
      CMD_GROUND, CMD_ACTIVE, CMD_EFFECT, CMD_FOCUS: begin
        if (used >= MAX_ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          slot = used;
          if (cmd == CMD_EFFECT) begin
            lx = x;
            ly = y;
            lz = z;
          end else begin
            lx = clamp24(x - org_x);
            ly = clamp24(y - org_y);
            lz = clamp24(z - org_z);
          end
          e_kind[slot] = 2'(cmd - CMD_GROUND);
          e_x[slot]    = lx;
          e_y[slot]    = ly;
          e_z[slot]    = lz;
          e_data[slot] = (cmd == CMD_GROUND) ? {48'd0, pl[15:0]} :
                         (cmd == CMD_FOCUS)  ? 64'd0 : pl;
          used++;
          if (cmd == CMD_GROUND || cmd == CMD_ACTIVE) begin
            vox = cell_of(lx, ly, lz);
            if (vox < 0) begin
              r.outside_grid = 1'b1;
            end else begin
              c_valid[vox] = 1'b1;
              c_slot[vox]  = slot;
              c_stamp[vox] = epoch;
            end
          end
          r.hit = 1'b1;
          put_entry(r, slot);
        end
      end
      CMD_LOOKUP, CMD_BLOCKED: begin
        vox = cell_of(x, y, z);
        if (vox < 0) begin
          r.outside_grid = 1'b1;
        end else if (c_valid[vox] && c_stamp[vox] == epoch) begin
          slot = c_slot[vox];
          put_entry(r, slot);
          r.hit = (cmd == CMD_LOOKUP) || (e_kind[slot] == qk);
        end
      end
      CMD_CONTAINS: begin
        r.hit = x >= org_x && x <= org_x + (GRID_X - 1) * CELL_Q &&
                y >= org_y && y <= org_y + (GRID_Y - 1) * CELL_Q &&
                z >= org_z && z <= org_z + (GRID_Z - 1) * CELL_Q;
        r.outside_grid = !r.hit;
      end
      CMD_READ: begin
        if (pl < 64'(used)) begin
          r.hit = 1'b1;
          put_entry(r, int'(pl[7:0]));
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(used);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      half_h = 16'd2048;
      half_v = 16'd2048;
      epoch  = '0;
      org_x  = 0;
      org_y  = 0;
      org_z  = 0;
      used   = 0;
      for (int i = 0; i < CELLS; i++) begin
        c_valid[i] = 1'b0;
        c_slot[i]  = 0;
        c_stamp[i] = '0;
      end
      pending_replies.delete();
    end else begin
      if (done) begin
        if (pending_replies.size() == 0) begin
          $display("%0t ns: result word with none awaited: expected none, got hit=%b count=%0d",
                   $time, hit, entry_count);
          faults++;
        end else begin
          want = pending_replies.pop_front();
          compare_field("hit", 64'(want.hit), 64'(hit));
          compare_field("table_full", 64'(want.table_full), 64'(table_full));
          compare_field("outside_grid", 64'(want.outside_grid), 64'(outside_grid));
          compare_field("entry_index", 64'(want.entry_index), 64'(entry_index));
          compare_field("entry_kind", 64'(want.entry_kind), 64'(entry_kind));
          compare_field("entry_x", {40'd0, want.entry_x}, {40'd0, entry_x});
          compare_field("entry_y", {40'd0, want.entry_y}, {40'd0, entry_y});
          compare_field("entry_z", {40'd0, want.entry_z}, {40'd0, entry_z});
          compare_field("entry_data", want.entry_data, entry_data);
          compare_field("entry_count", 64'(want.entry_count), 64'(entry_count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_H: half_h = cfg_data;
          REG_HALF_V: half_v = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        pending_replies.push_back(grid_reply(command, pos_x, pos_y, pos_z, payload,
                                             query_kind));
    end
    awaited_count <= pending_replies.size();
    fault_count   <= faults;
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the epoch tagged voxel occupancy grid
// Drives command and config words with random idle cycles, a directed opening
// then epochs of mostly well-formed random traffic; grid_checker does the
// predicting and comparing, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vog_pkg::*;

  localparam int         CELL_Q      = 256;    // one cell in Q16.8
  localparam int         ITEM_GOAL   = 1525;   // directed opening plus ~1500 random
  localparam logic [3:0] CMD_UNUSED  = 4'd15;  // no such command, count only
  localparam logic [1:0] KIND_GROUND = 2'd0;
  localparam logic [1:0] KIND_ACTIVE = 2'd1;
  localparam logic [1:0] KIND_FOCUS  = 2'd3;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic        busy;
  logic [3:0]  command      = '0;
  q_t          pos_x        = '0;
  q_t          pos_y        = '0;
  q_t          pos_z        = '0;
  logic [63:0] payload      = '0;
  logic [1:0]  query_kind   = '0;
  logic        done;
  logic        hit;
  logic        table_full;
  logic        outside_grid;
  logic [7:0]  entry_index;
  logic [1:0]  entry_kind;
  q_t          entry_x;
  q_t          entry_y;
  q_t          entry_z;
  logic [63:0] entry_data;
  logic [8:0]  entry_count;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;
  int          fault_count;
  int          awaited_count;

  bit gaps_on = 1'b1;  // random idle cycles on the sending sides
  int issued  = 0;     // command words accepted so far

  always #6 clk = ~clk;

  epoch_tagged_voxel_occupancy_grid DUT (.*);

  grid_checker grid_watch (.*);

  // One command word. start stays high from one word to the next unless an
  // idle cycle is drawn, so it never gets two assignments in one step.
  // Accepted at the first edge that sees start high and busy low.
  task automatic send_command(input logic [3:0] cmd, input q_t x, input q_t y, input q_t z,
                              input logic [63:0] pl, input logic [1:0] qk);
    while (gaps_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    pos_x      <= x;
    pos_y      <= y;
    pos_z      <= z;
    payload    <= pl;
    query_kind <= qk;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // One config word, held until cfg_ready is seen at an edge
  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    while (gaps_on && $urandom_range(99) < 22) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // New half extents, only once the block is idle: every command produces a
  // reply, so an empty expectation list and busy low mean nothing in flight.
  // The first edge is waited out so the count includes the last accepted word.
  task automatic retune(input logic [15:0] h, input logic [15:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0 || busy) @(posedge clk);
    write_reg(REG_HALF_H, h);
    write_reg(REG_HALF_V, v);
    cfg_valid <= 1'b0;
  endtask

  // Cell index on one axis: mostly in 0 to spread-1, now and then
  // just outside the grid on either side.
  function automatic int pick_cell(input int spread, input int bound);
    if ($urandom_range(99) < 4) return $urandom_range(1) ? -1 : bound;
    return $urandom_range(spread - 1);
  endfunction

  function automatic logic [15:0] pick_extent();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(4096));
      default: return 16'($urandom);
    endcase
  endfunction

  // Moving point: mostly moderate, sometimes anywhere or pinned to a limit
  function automatic longint pick_centre();
    case ($urandom_range(9)) inside
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return longint'(q_t'($urandom));
      default: return longint'($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  initial begin : stimulus
    int          phase, n, k, spread, roll, reg_share, pick, ax, ay, az;
    longint      cx, cy, cz, gx, gy, gz;
    logic [15:0] hh, hv;
    logic [31:0] stamp;
    logic [3:0]  cmd;
    int          seen_x [$];
    int          seen_y [$];
    int          seen_z [$];

    hh    = 16'd2048;
    hv    = 16'd2048;
    stamp = 32'd6;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed opening, half extents 8 cells on every axis ----
    retune(hh, hv);
    send_command(CMD_COUNT, '0, '0, '0, '0, '0);
    send_command(CMD_READ, '0, '0, '0, 64'd0, '0);            // empty table
    send_command(CMD_LOOKUP, '0, '0, '0, '0, '0);             // nothing valid yet
    // centre (10,20,30) cells: base corner at (2,12,22) cells
    send_command(CMD_START, 24'sd2560, 24'sd5120, 24'sd7680, {32'hA5A5_0000, 32'd5}, '0);
    send_command(CMD_GROUND, 24'sd2688, 24'sd5248, 24'sd7808, 64'hFFFF_FFFF_FFFF_ABCD, '0);
    send_command(CMD_ACTIVE, 24'sd512, 24'sd3072, 24'sd5632, '1, '0);    // cell 0
    send_command(CMD_EFFECT, -24'sd1, -24'sd1, -24'sd1, 64'h8000_0000_0000_0001, '0);
    // focus and ground at the coordinate limits: local saturates / leaves grid
    send_command(CMD_FOCUS, q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN), 64'd123, '0);
    send_command(CMD_GROUND, q_t'(Q_MAX), q_t'(Q_MAX), q_t'(Q_MAX), '0, '0);
    send_command(CMD_LOOKUP, 24'sd2176, 24'sd2176, 24'sd2176, '0, '0);
    send_command(CMD_BLOCKED, 24'sd2176, 24'sd2176, 24'sd2176, '0, KIND_GROUND);
    send_command(CMD_BLOCKED, 24'sd2176, 24'sd2176, 24'sd2176, '0, KIND_FOCUS);
    // small negative local rounds toward zero into cell 0
    send_command(CMD_BLOCKED, -24'sd255, -24'sd255, -24'sd255, '0, KIND_ACTIVE);
    send_command(CMD_LOOKUP, 24'sd4096, 24'sd0, 24'sd0, '0, '0);   // one past the edge
    // box edges: corner, far corner, one step beyond on X, one short on Z
    send_command(CMD_CONTAINS, 24'sd512, 24'sd3072, 24'sd5632, '0, '0);
    send_command(CMD_CONTAINS, 24'sd4352, 24'sd6912, 24'sd9472, '0, '0);
    send_command(CMD_CONTAINS, 24'sd4353, 24'sd6912, 24'sd9472, '0, '0);
    send_command(CMD_CONTAINS, 24'sd512, 24'sd3072, 24'sd5631, '0, '0);
    send_command(CMD_READ, '0, '0, '0, 64'd1, '0);
    send_command(CMD_READ, '0, '0, '0, '1, '0);
    send_command(CMD_UNUSED, '1, '1, '1, '1, '1);
    // same stamp again: old cells stay live and name stale entries
    send_command(CMD_START, 24'sd2560, 24'sd5120, 24'sd7680, {32'h0000_FFFF, 32'd5}, '0);
    send_command(CMD_LOOKUP, 24'sd2176, 24'sd2176, 24'sd2176, '0, '0);
    // base corner pinned at the bottom of the range
    send_command(CMD_START, q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN), {32'd0, stamp}, '0);
    send_command(CMD_CONTAINS, q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN), '0, '0);

    // ---- random epochs ----
    for (phase = 0; issued < ITEM_GOAL; phase++) begin
      if (phase < 3 || $urandom_range(3) == 0) begin
        case (phase)
          0: begin
            hh = 16'd0;
            hv = 16'hFFFF;
          end
          1: begin
            hh = 16'hFFFF;
            hv = 16'd0;
          end
          default: begin
            hh = pick_extent();
            hv = pick_extent();
          end
        endcase
        retune(hh, hv);
      end
      gaps_on = !(phase >= 6 && phase < 11);   // long run with no idle cycles

      case ($urandom_range(9)) inside
        0, 1:    stamp = $urandom;
        2:       ;                             // repeat the stamp
        default: stamp = stamp + 32'd1;
      endcase
      cx = pick_centre();
      cy = pick_centre();
      cz = pick_centre();
      send_command(CMD_START, q_t'(cx), q_t'(cy), q_t'(cz), {$urandom, stamp}, 2'($urandom));
      // corner as the block should place it, ignoring saturation
      gx = ((cx - longint'(hh)) >>> 8) <<< 8;
      gy = ((cy - longint'(hh)) >>> 8) <<< 8;
      gz = ((cz - longint'(hv)) >>> 8) <<< 8;
      seen_x.delete();
      seen_y.delete();
      seen_z.delete();

      case ($urandom_range(2))
        0:       spread = 2;
        1:       spread = 4;
        default: spread = GRID_X;
      endcase
      // phase 3 fills the table past its capacity
      reg_share = (phase == 3) ? 80 : 35;
      n = (phase == 3) ? 330 : $urandom_range(15, 70);

      for (k = 0; k < n && issued < ITEM_GOAL; k++) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          // noise: every field anywhere, unused commands included
          send_command(4'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom),
                       {$urandom, $urandom}, 2'($urandom));
        end else if (roll < 10 + reg_share) begin
          cmd = CMD_GROUND + 4'($urandom_range(3));
          ax  = pick_cell(spread, GRID_X);
          ay  = pick_cell(spread, GRID_Y);
          az  = pick_cell(spread, GRID_Z);
          if (cmd == CMD_EFFECT) begin
            send_command(cmd, q_t'(ax * CELL_Q + int'($urandom_range(255))),
                         q_t'(ay * CELL_Q + int'($urandom_range(255))),
                         q_t'(az * CELL_Q + int'($urandom_range(255))),
                         {$urandom, $urandom}, 2'($urandom));
          end else begin
            send_command(cmd, q_t'(gx + ax * CELL_Q + int'($urandom_range(255))),
                         q_t'(gy + ay * CELL_Q + int'($urandom_range(255))),
                         q_t'(gz + az * CELL_Q + int'($urandom_range(255))),
                         {$urandom, $urandom}, 2'($urandom));
            if (cmd != CMD_FOCUS) begin
              seen_x.push_back(ax);
              seen_y.push_back(ay);
              seen_z.push_back(az);
            end
          end
        end else if (roll < 10 + reg_share + 25) begin
          // lookups mostly aim at cells claimed in this epoch
          if (seen_x.size() > 0 && $urandom_range(3) != 0) begin
            pick = $urandom_range(seen_x.size() - 1);
            ax   = seen_x[pick];
            ay   = seen_y[pick];
            az   = seen_z[pick];
          end else begin
            ax = pick_cell(GRID_X, GRID_X);
            ay = pick_cell(GRID_Y, GRID_Y);
            az = pick_cell(GRID_Z, GRID_Z);
          end
          send_command($urandom_range(1) ? CMD_LOOKUP : CMD_BLOCKED,
                       q_t'(ax * CELL_Q + int'($urandom_range(255))),
                       q_t'(ay * CELL_Q + int'($urandom_range(255))),
                       q_t'(az * CELL_Q + int'($urandom_range(255))),
                       {$urandom, $urandom}, 2'($urandom));
        end else if (roll < 10 + reg_share + 33) begin
          // a cell's margin either side of the box
          send_command(CMD_CONTAINS,
                       q_t'(gx + int'($urandom_range(17 * CELL_Q)) - CELL_Q),
                       q_t'(gy + int'($urandom_range(17 * CELL_Q)) - CELL_Q),
                       q_t'(gz + int'($urandom_range(17 * CELL_Q)) - CELL_Q),
                       {$urandom, $urandom}, 2'($urandom));
        end else if (roll < 10 + reg_share + 41) begin
          send_command(CMD_READ, q_t'($urandom), q_t'($urandom), q_t'($urandom),
                       $urandom_range(7) == 0 ? {$urandom, $urandom}
                                              : 64'($urandom_range(MAX_ENTRIES + 4)),
                       2'($urandom));
        end else begin
          send_command(CMD_COUNT, q_t'($urandom), q_t'($urandom), q_t'($urandom),
                       {$urandom, $urandom}, 2'($urandom));
        end
      end
    end

    // ---- drain: wait for the last replies, then a quiet wait before the verdict ----
    start <= 1'b0;
    @(posedge clk);
    for (k = 0; awaited_count != 0 && k < 400; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_count != 0)
      $display("%0t ns: %0d result words never arrived", $time, awaited_count);
    if (fault_count == 0 && awaited_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: clearing pass plus every word at worst latency, many times over
  initial begin : watchdog
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== epoch_tagged_voxel_occupancy_grid.f =====
hdl/vog_pkg.sv
hdl/vog_ram.sv
hdl/vog_geom.sv
hdl/epoch_tagged_voxel_occupancy_grid.sv
verif/grid_checker.sv
verif/tb.sv
